// ===== sv/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types, codes and constants for the confirmable-message
// retransmission tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package crt_pkg;

  localparam int SLOT_COUNT_DEF = 4;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;
  localparam int SLOT_IDX_W = 2;

  localparam logic [15:0] ACK_BASE_RST   = 16'd2000;
  localparam logic [3:0]  RETX_LIMIT_RST = 4'd3;
  localparam logic [15:0] NEXT_MID_RST   = 16'd1;
  localparam logic [15:0] NEXT_TOK_RST   = 16'h0100;

  localparam logic [1:0] ACK_TYPE      = 2'd2;
  localparam logic [3:0] ACK_TOKEN_LEN = 4'd2;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd8;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RX   = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_ACK_BASE   = 1'b0,
    CFG_RETX_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEND,
    ST_ACK,
    ST_TICK,
    ST_FLUSH
  } state_t;

  // One result word
  typedef struct packed {
    logic                  found;
    logic                  evt;
    logic [15:0]           mid;
    logic [15:0]           tok;
    logic [15:0]           dest;
    logic [SLOT_IDX_W-1:0] slot_index;
  } res_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic send;
    logic ack_step;
    logic tick_step;
    logic flush;
  } crt_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  ack_ok;
    logic  ack_hit;
    logic  scan_last;
    logic  tick_stall;
    logic  pend_valid;
    logic  out_free;
  } crt_stat_t;

endpackage

`default_nettype wire

// ===== sv/crt_ctrl.sv =====
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: accepts one word, decodes its kind and steps the datapath
// through send, ACK search, tick scan and result flush.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_ctrl
  import crt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire crt_stat_t st,
  output crt_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (st.kind)
          KIND_SEND: state_nxt = ST_SEND;
          KIND_RX:   state_nxt = st.ack_ok ? ST_ACK : ST_IDLE;
          KIND_TICK: state_nxt = ST_TICK;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_SEND: state_nxt = ST_FLUSH;
      ST_ACK: begin
        if (st.ack_hit || st.scan_last) state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        if (!st.tick_stall && st.scan_last) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!st.pend_valid || st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DECODE: cmd.scan_clr  = 1'b1;
      ST_SEND:   cmd.send      = 1'b1;
      ST_ACK:    cmd.ack_step  = 1'b1;
      ST_TICK:   cmd.tick_step = 1'b1;
      ST_FLUSH:  cmd.flush     = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/crt_dp.sv =====
// ----------------------------------------------------------------------------
// crt_dp
// Datapath: slot table, ID and token counters, timeout check for the
// scanned slot, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_dp
  import crt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire crt_cmd_t              cmd,
  output crt_stat_t                  st,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [15:0]           cfg_wdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // configuration
  logic [15:0] ack_base_r;
  logic [3:0]  retx_limit_r;

  // captured item
  kind_t       kind_r;
  logic [15:0] dest_r;
  logic [31:0] now_r;
  logic [7:0]  hdr_r;
  logic [15:0] rx_mid_r;
  logic [7:0]  flen_r;

  // slot table
  logic [SLOT_COUNT-1:0] slot_ready_r;
  logic [15:0]           slot_mid_r     [SLOT_COUNT];
  logic [15:0]           slot_dest_r    [SLOT_COUNT];
  logic [31:0]           slot_sent_r    [SLOT_COUNT];
  logic [3:0]            slot_retries_r [SLOT_COUNT];

  logic [15:0] next_mid_r, next_mid_nxt;
  logic [15:0] next_tok_r;
  logic [IDX_W-1:0] scan_r;

  res_t pend_r;
  logic pend_valid_r;
  res_t out_r;
  logic out_valid_r;
  logic out_last_r;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [15:0]      send_mid;
  res_t             send_res;
  res_t             retx_res;
  logic [31:0]      elapsed;
  logic [31:0]      timeout;
  logic             due;
  logic             drop;
  logic             emit;
  logic             out_free;
  logic             tick_stall;
  logic             ack_hit;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!free_found && !slot_ready_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // skip message ID zero
  always_comb begin
    if (next_mid_r == 16'd0) begin
      send_mid     = next_mid_r + 16'd1;
      next_mid_nxt = next_mid_r + 16'd2;
    end else begin
      send_mid     = next_mid_r;
      next_mid_nxt = next_mid_r + 16'd1;
    end
  end

  always_comb begin
    send_res.found      = free_found;
    send_res.evt        = 1'b0;
    send_res.mid        = send_mid;
    send_res.tok        = next_tok_r;
    send_res.dest       = dest_r;
    send_res.slot_index = free_found ? SLOT_IDX_W'(free_idx) : '0;
  end

  // Retries never exceed 15, so the shifted timeout fits in 31 bits.
  assign elapsed  = now_r - slot_sent_r[scan_r];
  assign timeout  = {16'd0, ack_base_r} << slot_retries_r[scan_r];
  assign due      = slot_ready_r[scan_r] && (elapsed >= timeout);
  assign drop     = due && (slot_retries_r[scan_r] >= retx_limit_r);
  assign emit     = due && !drop;
  assign out_free = !out_valid_r || out_tready;
  assign tick_stall = emit && pend_valid_r && !out_free;
  assign ack_hit  = slot_ready_r[scan_r] && (slot_mid_r[scan_r] == rx_mid_r);

  always_comb begin
    retx_res.found      = 1'b1;
    retx_res.evt        = 1'b1;
    retx_res.mid        = slot_mid_r[scan_r];
    retx_res.tok        = 16'd0;
    retx_res.dest       = slot_dest_r[scan_r];
    retx_res.slot_index = SLOT_IDX_W'(scan_r);
  end

  always_comb begin
    st.kind       = kind_r;
    st.ack_ok     = (flen_r >= MIN_FRAME_LEN) && (hdr_r[3:0] == ACK_TOKEN_LEN) &&
                    (hdr_r[5:4] == ACK_TYPE);
    st.ack_hit    = ack_hit;
    st.scan_last  = (scan_r == IDX_W'(SLOT_COUNT - 1));
    st.tick_stall = tick_stall;
    st.pend_valid = pend_valid_r;
    st.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_base_r   <= ACK_BASE_RST;
      retx_limit_r <= RETX_LIMIT_RST;
      slot_ready_r <= '0;
      next_mid_r   <= NEXT_MID_RST;
      next_tok_r   <= NEXT_TOK_RST;
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      kind_r       <= KIND_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_ACK_BASE:   ack_base_r   <= cfg_wdata;
          CFG_RETX_LIMIT: retx_limit_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      if (out_tready) out_valid_r <= 1'b0;

      if (cmd.load) kind_r <= kind_t'(in_tuser);
      if (cmd.scan_clr) scan_r <= '0;

      if (cmd.send) begin
        next_mid_r   <= next_mid_nxt;
        next_tok_r   <= next_tok_r + 16'd1;
        pend_valid_r <= 1'b1;
        if (free_found) slot_ready_r[free_idx] <= 1'b1;
      end

      if (cmd.ack_step) begin
        if (ack_hit) slot_ready_r[scan_r] <= 1'b0;
        else         scan_r <= scan_r + IDX_W'(1);
      end

      if (cmd.tick_step && !tick_stall) begin
        scan_r <= scan_r + IDX_W'(1);
        if (drop) slot_ready_r[scan_r] <= 1'b0;
        if (emit) begin
          pend_valid_r <= 1'b1;
          // push the earlier result out, it is not the last one
          if (pend_valid_r) out_valid_r <= 1'b1;
        end
      end

      if (cmd.flush && pend_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dest_r   <= in_tdata[15:0];
      now_r    <= in_tdata[47:16];
      hdr_r    <= in_tdata[55:48];
      rx_mid_r <= in_tdata[71:56];
      flen_r   <= in_tdata[79:72];
    end

    if (cmd.send) begin
      pend_r <= send_res;
      if (free_found) begin
        slot_mid_r[free_idx]     <= send_mid;
        slot_dest_r[free_idx]    <= dest_r;
        slot_sent_r[free_idx]    <= now_r;
        slot_retries_r[free_idx] <= 4'd0;
      end
    end

    if (cmd.tick_step && !tick_stall && emit) begin
      pend_r                 <= retx_res;
      slot_sent_r[scan_r]    <= now_r;
      slot_retries_r[scan_r] <= slot_retries_r[scan_r] + 4'd1;
      if (pend_valid_r) begin
        out_r      <= pend_r;
        out_last_r <= 1'b0;
      end
    end

    if (cmd.flush && pend_valid_r && out_free) begin
      out_r      <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.slot_index, out_r.dest, out_r.tok, out_r.mid};
  assign out_tuser  = {out_r.found, out_r.evt};
  assign out_tlast  = out_last_r;

  a_send_mid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.evt |-> out_r.mid != 16'd0)
    else $error("first send carries message ID zero");

  a_retx_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.evt |-> out_r.found && out_r.tok == 16'd0)
    else $error("retransmission without slot or with a token");

  a_stall_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_step && tick_stall |=> $stable(scan_r) && $stable(pend_r))
    else $error("tick scan advanced while the pending result was blocked");

  a_claim_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send && free_found |=> slot_ready_r[$past(free_idx)])
    else $error("claimed slot not marked ready");

endmodule

`default_nettype wire

// ===== sv/coap_retransmit_tracker.sv =====
// ----------------------------------------------------------------------------
// coap_retransmit_tracker
// Confirmable-message slot table with exponential-backoff retransmission.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Contents
// in_      slave      tvalid/tready          kind on tuser, frame/send fields
// out_     master     tvalid/tready/tlast    send or retransmit result
// cfg_     write      cfg_we                 ack_timeout_base_ms, limit
//
// A send steps through accept, decode, claim and flush. A received frame
// is decoded, then a valid ACK searches at most SLOT_COUNT slots in turn;
// a tick is decoded, scans each slot through the single timeout compare
// and flushes. A stalled output holds the tick scan when a second result
// is found. Reset is synchronous, active low and frees every slot at once.
// ----------------------------------------------------------------------------
`default_nettype none

module coap_retransmit_tracker
  import crt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // dest_node[15:0], now_ms[47:16], header_byte[55:48],
  // rx_message_id[71:56], frame_len[79:72]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // message_id[15:0], token_value[31:16], dest_out[47:32],
  // slot_index[49:48], zero[55:50]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // event_res[0], slot_found[1]
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [15:0]           cfg_wdata
);

  crt_cmd_t  cmd;
  crt_stat_t st;

  crt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  crt_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the confirmable-message retransmission tracker.
// Sends, received frame headers and ticks go in on the input stream. A
// model of the slot table, kept in step with every accepted word, forecasts
// each send and retransmit result, and the result stream is compared with
// the forecast field by field. Both stream sides stall at random. The
// backoff registers are changed only while the block is quiet.
// ----------------------------------------------------------------------------
module tb_top;
  import crt_pkg::*;

  localparam int SLOTS         = SLOT_COUNT_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES  = 2000000;

  // CoAP header fields
  localparam logic [1:0] COAP_VER = 2'd1;
  localparam logic [1:0] MSG_CON  = 2'd0;
  localparam logic [1:0] MSG_NON  = 2'd1;
  localparam logic [1:0] MSG_RST  = 2'd3;

  typedef struct packed {
    logic        evt;
    logic [15:0] mid;
    logic [15:0] tok;
    logic [15:0] dest;
    logic [1:0]  slot;
    logic        found;
    logic        last;
  } announce_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // dest_node, now_ms, header_byte, rx_message_id, frame_len (low bit up)
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // kind
  logic [1:0]            in_tuser   = KIND_NONE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // message_id, token_value, dest_out, slot_index, zero pad (low bit up)
  logic [OUT_DATA_W-1:0] out_tdata;
  // event_res, slot_found (low bit up)
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_addr   = 1'b0;
  logic [15:0]           cfg_wdata  = '0;

  coap_retransmit_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Slot table model
  logic        slot_busy  [SLOTS];
  logic [15:0] slot_mid   [SLOTS];
  logic [15:0] slot_dst   [SLOTS];
  logic [31:0] slot_t0    [SLOTS];
  logic [3:0]  slot_tries [SLOTS];
  logic [15:0] mid_ctr = NEXT_MID_RST;
  logic [15:0] tok_ctr = NEXT_TOK_RST;
  logic [15:0] base_ms = ACK_BASE_RST;
  logic [3:0]  retry_cap = RETX_LIMIT_RST;

  announce_t announce_q[$];
  int        bad_words = 0;
  int        cycles    = 0;
  bit        idle_en   = 1'b1;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i]  = 1'b0;
      slot_mid[i]   = '0;
      slot_dst[i]   = '0;
      slot_t0[i]    = '0;
      slot_tries[i] = '0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= !idle_en || ($urandom_range(0, 99) >= 29);

  // Advance the table model by one accepted word
  task automatic track_item(kind_t k, logic [15:0] dest, logic [31:0] now,
                            logic [7:0] hdr, logic [15:0] rxm, logic [7:0] flen);
    logic [15:0] m;
    logic [15:0] t;
    logic [31:0] tmo;
    int          sh;
    int          hit;
    announce_t   w;
    announce_t   burst[$];
    hit = -1;
    case (k)
      KIND_SEND: begin
        m = mid_ctr;
        mid_ctr = mid_ctr + 16'd1;
        if (m == 16'd0) begin
          m = mid_ctr;
          mid_ctr = mid_ctr + 16'd1;
        end
        t = tok_ctr;
        tok_ctr = tok_ctr + 16'd1;
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && !slot_busy[i]) hit = i;
        w = '{evt: 1'b0, mid: m, tok: t, dest: dest, slot: 2'd0, found: 1'b0,
              last: 1'b1};
        if (hit >= 0) begin
          slot_busy[hit]  = 1'b1;
          slot_mid[hit]   = m;
          slot_dst[hit]   = dest;
          slot_t0[hit]    = now;
          slot_tries[hit] = 4'd0;
          w.slot  = hit[1:0];
          w.found = 1'b1;
        end
        announce_q.push_back(w);
      end
      KIND_RX: begin
        if (flen >= MIN_FRAME_LEN && hdr[3:0] == ACK_TOKEN_LEN && hdr[5:4] == ACK_TYPE)
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && slot_busy[i] && slot_mid[i] == rxm) begin
              hit = i;
              slot_busy[i]  = 1'b0;
              slot_mid[i]   = '0;
              slot_tries[i] = 4'd0;
            end
      end
      KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i]) begin
            sh  = (slot_tries[i] > 21) ? 21 : int'(slot_tries[i]);
            tmo = {16'd0, base_ms} << sh;
            if (now - slot_t0[i] >= tmo) begin
              if (slot_tries[i] >= retry_cap) begin
                // drop silently
                slot_busy[i] = 1'b0;
                slot_mid[i]  = '0;
              end else begin
                w = '{evt: 1'b1, mid: slot_mid[i], tok: 16'd0,
                      dest: slot_dst[i], slot: i[1:0], found: 1'b1,
                      last: 1'b0};
                burst.push_back(w);
                slot_t0[i]    = now;
                slot_tries[i] = slot_tries[i] + 4'd1;
              end
            end
          end
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[j]) announce_q.push_back(burst[j]);
      end
      default: ;
    endcase
  endtask

  // Offer one word and hold it until the block takes it
  task automatic push_word(kind_t k, logic [15:0] dest, logic [31:0] now,
                           logic [7:0] hdr, logic [15:0] rxm, logic [7:0] flen);
    while (idle_en && $urandom_range(0, 99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {flen, rxm, hdr, now, dest};
    do @(posedge clk); while (!in_tready);
    track_item(k, dest, now, hdr, rxm, flen);
  endtask

  task automatic send_msg(logic [15:0] dest, logic [31:0] now);
    push_word(KIND_SEND, dest, now, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_frame(logic [7:0] hdr, logic [15:0] rxm, logic [7:0] flen);
    push_word(KIND_RX, 16'($urandom), $urandom, hdr, rxm, flen);
  endtask

  task automatic send_tick(logic [31:0] now);
    push_word(KIND_TICK, 16'($urandom), now, 8'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  // Drop valid, drain all forecast results, then let a scan finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (announce_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACK_BASE) base_ms = val;
    else retry_cap = val[3:0];
    @(posedge clk);
  endtask

  // Result check
  always @(posedge clk) begin
    announce_t w;
    logic      ok;
    if (rst_n && out_tvalid && out_tready) begin
      if (announce_q.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected result word: evt=%0d mid=%h tok=%h dest=%h slot=%0d",
                   out_tuser[0], out_tdata[15:0], out_tdata[31:16],
                   out_tdata[47:32], out_tdata[49:48]);
      end else begin
        w  = announce_q.pop_front();
        ok = out_tuser[0] == w.evt && out_tuser[1] == w.found &&
             out_tdata[15:0] == w.mid && out_tdata[31:16] == w.tok &&
             out_tdata[47:32] == w.dest && out_tdata[49:48] == w.slot &&
             out_tdata[55:50] == 6'd0 && out_tlast == w.last;
        if (!ok) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("mismatch exp: evt=%0d found=%0d mid=%h tok=%h dest=%h slot=%0d last=%0d",
                     w.evt, w.found, w.mid, w.tok, w.dest, w.slot, w.last);
            $display("         got: evt=%0d found=%0d mid=%h tok=%h dest=%h slot=%0d last=%0d pad=%h",
                     out_tuser[0], out_tuser[1], out_tdata[15:0], out_tdata[31:16],
                     out_tdata[47:32], out_tdata[49:48], out_tlast, out_tdata[55:50]);
          end
        end
      end
    end
  end

  // Fill the table past full, plus an unknown kind
  task automatic test_first_sends();
    send_msg(16'h0000, 32'd0);
    send_msg(16'hFFFF, 32'hFFFF_FFFF);
    send_msg(16'hA5A5, 32'd100);
    send_msg(16'h5A5A, 32'd200);
    send_msg(16'h1234, 32'd250);
    push_word(KIND_NONE, '1, '1, '1, '1, '1);
  endtask

  // Frames that must not free a slot, then a good ACK and a stray one
  task automatic test_ack_frames();
    send_frame({COAP_VER, ACK_TYPE, ACK_TOKEN_LEN}, slot_mid[1], 8'd7);
    send_frame({COAP_VER, ACK_TYPE, 4'd3}, slot_mid[1], 8'd255);
    send_frame({COAP_VER, MSG_CON, ACK_TOKEN_LEN}, slot_mid[1], 8'd20);
    send_frame({COAP_VER, MSG_NON, ACK_TOKEN_LEN}, slot_mid[1], 8'd20);
    send_frame({COAP_VER, MSG_RST, ACK_TOKEN_LEN}, slot_mid[1], 8'd20);
    send_frame({COAP_VER, ACK_TYPE, ACK_TOKEN_LEN}, slot_mid[1], 8'd255);
    send_frame({COAP_VER, ACK_TYPE, ACK_TOKEN_LEN}, 16'hFFFF, 8'd64);
    send_msg(16'h00FF, 32'd300);
  endtask

  // Walk every slot through the default backoff until it drops
  task automatic test_backoff();
    send_tick(32'd300);
    send_tick(32'd2300);
    send_tick(32'd6300);
    send_tick(32'd14300);
    send_tick(32'd30300);
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(CFG_ACK_BASE, 16'd1);
    write_reg(CFG_RETX_LIMIT, 16'hFFF0);
    send_msg(16'h0F0F, 32'd10);
    send_tick(32'd11);
    settle();
    write_reg(CFG_ACK_BASE, 16'd0);
    write_reg(CFG_RETX_LIMIT, 16'h000F);
    send_msg(16'hF0F0, 32'd500);
    send_tick(32'd500);
    send_frame({COAP_VER, ACK_TYPE, ACK_TOKEN_LEN}, slot_mid[0], MIN_FRAME_LEN);
    settle();
    write_reg(CFG_ACK_BASE, 16'hFFFF);
    write_reg(CFG_RETX_LIMIT, 16'd15);
    send_msg(16'h8001, 32'h8000_0000);
    send_tick(32'h8000_FFFE);
    send_tick(32'h8000_FFFF);
  endtask

  // Mostly coherent traffic: sends at the running time, ACKs of live IDs,
  // ticks that step the time forward; some noise and stale times mixed in
  task automatic test_traffic(int words, logic [15:0] base, logic [15:0] cap_word,
                              logic [31:0] start_ms, bit calm);
    logic [31:0] clock_ms;
    logic [15:0] dest;
    logic [31:0] now;
    logic [7:0]  hdr;
    logic [15:0] rxm;
    logic [7:0]  flen;
    int          pick;
    int          s;
    int          done;
    settle();
    write_reg(CFG_ACK_BASE, base);
    write_reg(CFG_RETX_LIMIT, cap_word);
    idle_en  = !calm;
    clock_ms = start_ms;
    done     = 0;
    while (done < words) begin
      dest = 16'($urandom);
      now  = $urandom;
      hdr  = 8'($urandom);
      rxm  = 16'($urandom);
      flen = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_word(KIND_NONE, dest, now, hdr, rxm, flen);
      end else if (pick < 36) begin
        push_word(KIND_SEND, dest, clock_ms, hdr, rxm, flen);
        done++;
      end else if (pick < 64) begin
        s = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS && !slot_busy[s]; i++) s = (s + 1) % SLOTS;
        if (slot_busy[s] && $urandom_range(0, 99) < 80) begin
          hdr  = {hdr[7:6], ACK_TYPE, ACK_TOKEN_LEN};
          flen = 8'($urandom_range(8, 255));
          rxm  = slot_mid[s];
        end
        push_word(KIND_RX, dest, now, hdr, rxm, flen);
        done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 85) clock_ms = clock_ms + $urandom_range(0, 3 * int'(base_ms));
        else if (pick < 95) clock_ms = clock_ms + $urandom;
        // a stale or random time now and then
        push_word(KIND_TICK, dest, (pick < 95) ? clock_ms : now, hdr, rxm, flen);
        done++;
      end
    end
    idle_en = 1'b1;
  endtask

  // Back-to-back sends until the table is full and past it
  task automatic test_full_table();
    settle();
    idle_en = 1'b0;
    repeat (6) send_msg(16'($urandom), $urandom);
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_sends();
    test_ack_frames();
    test_backoff();
    test_register_extremes();
    test_traffic(80, 16'd40, 16'd3, 32'd0, 1'b0);
    test_traffic(80, 16'd1, 16'hFFF0, 32'hFFFF_F000, 1'b0);
    test_traffic(80, 16'hFFFF, 16'd15, $urandom, 1'b1);
    test_traffic(90, 16'($urandom_range(1, 500)), 16'($urandom_range(0, 15)),
                 $urandom, 1'b0);
    test_full_table();
    settle();
    if (bad_words == 0 && announce_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/crt_pkg.sv
sv/crt_ctrl.sv
sv/crt_dp.sv
sv/coap_retransmit_tracker.sv
sim/tb_top.sv
